FILE: rtl/tlvs_pkg.sv
package tlvs_pkg;

   localparam int LENGTH_BITS_DEF = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [31:0] record_id;
      logic [31:0] payload_offset;
      logic [31:0] payload_size;
      logic        status;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rec_type rec;
   } push_type;

endpackage

FILE: rtl/tlvs_ifs.sv
interface tlvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_start;

   modport source (output valid, output data_byte, output buffer_start, input ready);
   modport sink (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface tlvs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] record_id;
   logic [31:0] payload_offset;
   logic [31:0] payload_size;
   logic        status;

   modport source (output valid, output record_id, output payload_offset,
                   output payload_size, output status, input ready);
   modport sink (input valid, input record_id, input payload_offset,
                 input payload_size, input status, output ready);
endinterface

interface tlvs_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] buffer_length;

   modport source (output valid, output buffer_length, input ready);
   modport sink (input valid, input buffer_length, output ready);
endinterface

FILE: rtl/tlvs_front.sv
module tlvs_front #(
   parameter int LENGTH_BITS = tlvs_pkg::LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   tlvs_req_if.sink               req,
   input  logic [LENGTH_BITS-1:0] len,
   input  logic                   q_full,
   output tlvs_pkg::push_type     push
);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_STOPPED = 2'd2;
   localparam logic [2:0] HDR_FIRST  = 3'd0;
   localparam logic [2:0] HDR_LAST   = 3'd7;
   localparam int         SUM_W      = 34;

   logic [LENGTH_BITS-1:0] pos_ff, pos_in, pos_cur;
   logic [LENGTH_BITS-1:0] skip_ff, skip_in;
   logic [1:0]             phase_ff, phase_in, phase_cur;
   logic [2:0]             hcnt_ff, hcnt_in, hcnt_cur;
   logic [31:0]            id_ff, id_in;
   logic [31:0]            size_ff, size_in;
   logic [31:0]            size_full;
   logic [SUM_W-1:0]       off_w;
   logic                   accept;
   logic                   short_tail;
   logic                   bad;

   assign req.ready = ~q_full;

   always_comb begin
      accept    = req.valid & ~q_full;
      pos_cur   = req.buffer_start ? '0 : pos_ff;
      phase_cur = req.buffer_start ? PH_HEADER : phase_ff;
      hcnt_cur  = req.buffer_start ? HDR_FIRST : hcnt_ff;

      size_full  = {req.data_byte, size_ff[23:0]};
      off_w      = SUM_W'(pos_cur) + SUM_W'(1);
      bad        = (off_w + SUM_W'(size_full)) > SUM_W'(len);
      short_tail = (hcnt_cur == HDR_FIRST) &&
                   ((SUM_W'(pos_cur) + SUM_W'(8)) > SUM_W'(len));

      pos_in   = pos_ff;
      skip_in  = skip_ff;
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      id_in    = id_ff;
      size_in  = size_ff;

      push.valid              = 1'b0;
      push.rec.record_id      = id_ff;
      push.rec.payload_offset = off_w[31:0];
      push.rec.payload_size   = size_full;
      push.rec.status         = bad;

      if (accept) begin
         phase_in = phase_cur;
         hcnt_in  = hcnt_cur;
         // saturate the position at the top of the length range
         pos_in   = (pos_cur == '1) ? pos_cur : pos_cur + 1'b1;
         case (phase_cur)
            PH_HEADER: begin
               if (short_tail) begin
                  phase_in = PH_STOPPED;
               end else begin
                  if (!hcnt_cur[2]) begin
                     id_in[{hcnt_cur[1:0], 3'b000} +: 8] = req.data_byte;
                  end else begin
                     size_in[{hcnt_cur[1:0], 3'b000} +: 8] = req.data_byte;
                  end
                  if (hcnt_cur == HDR_LAST) begin
                     hcnt_in    = HDR_FIRST;
                     push.valid = 1'b1;
                     if (bad) begin
                        phase_in = PH_STOPPED;
                     end else if (size_full != '0) begin
                        skip_in  = size_full[LENGTH_BITS-1:0];
                        phase_in = PH_PAYLOAD;
                     end
                  end else begin
                     hcnt_in = hcnt_cur + 3'd1;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end
               // last payload byte: next byte opens a header
               if (skip_ff[LENGTH_BITS-1:1] == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               // stopped: drop bytes until a new buffer starts
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         skip_ff  <= '0;
         phase_ff <= PH_HEADER;
         hcnt_ff  <= HDR_FIRST;
      end else begin
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      size_ff <= size_in;
   end

endmodule

FILE: rtl/tlvs_queue.sv
module tlvs_queue (
   input  logic               clock,
   input  logic               reset,
   input  tlvs_pkg::push_type push,
   output logic               full,
   tlvs_rsp_if.source         rsp
);

   localparam int AW = tlvs_pkg::QUEUE_AW;

   tlvs_pkg::rec_type mem_ff [tlvs_pkg::QUEUE_DEPTH];

   logic [AW:0]   count_ff, count_in;
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic          pop;
   logic          put;

   assign full = (count_ff == (AW+1)'(tlvs_pkg::QUEUE_DEPTH));

   assign rsp.valid          = (count_ff != '0);
   assign rsp.record_id      = mem_ff[rd_ff].record_id;
   assign rsp.payload_offset = mem_ff[rd_ff].payload_offset;
   assign rsp.payload_size   = mem_ff[rd_ff].payload_size;
   assign rsp.status         = mem_ff[rd_ff].status;

   always_comb begin
      pop      = rsp.valid & rsp.ready;
      put      = push.valid;
      wr_in    = put ? AW'(wr_ff + 1'b1) : wr_ff;
      rd_in    = pop ? AW'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (put && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !put) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         mem_ff[wr_ff] <= push.rec;
      end
   end

endmodule

FILE: rtl/tlv_record_index_scanner.sv
// channel | dir | handshake     | beat contents
// req_ch  | in  | valid/ready   | data_byte[7:0], buffer_start
// rsp_ch  | out | valid/ready   | record_id, payload_offset, payload_size, status
// csr_ch  | in  | valid/ready   | buffer_length[31:0], ready held high
//
// One byte beat is taken per cycle unless the record queue is full; a record leaves
// the queue in the cycle after its last header byte at the earliest. Header bytes,
// payload skipping and the fit check all resolve in the same cycle the byte is taken.
// Reset returns the scan to the header phase at position 0 and clears the length.
// A stalled result side fills the four-entry record queue; req_ch.ready drops
// only while that queue is full.
module tlv_record_index_scanner #(
   parameter int LENGTH_BITS = tlvs_pkg::LENGTH_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   tlvs_req_if.sink    req_ch,
   tlvs_rsp_if.source  rsp_ch,
   tlvs_csr_if.sink    csr_ch
);

   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   q_full;
   tlvs_pkg::push_type     push;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      len_in = len_ff;
      if (csr_ch.valid) begin
         len_in = csr_ch.buffer_length[LENGTH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   tlvs_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .len    (len_ff),
      .q_full (q_full),
      .push   (push)
   );

   tlvs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .rsp   (rsp_ch)
   );

endmodule

FILE: tb/sv/tlv_record_index_scanner_tb.sv
module tlv_record_index_scanner_tb;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_BYTES  = 650;
   localparam int QUIET_TAIL    = 80;
   localparam int PHASE_BYTES   = 60;
   localparam int PHASE_BUFFERS = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;

   localparam logic ST_OK       = 1'b0;
   localparam logic ST_BAD_SIZE = 1'b1;

   localparam tlvs_pkg::rec_type NO_REC = '0;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_STOPPED = 2'd2
   } scan_phase_type;

   typedef struct packed {
      logic [7:0]        data;
      logic              first;
      logic              typed;
      tlvs_pkg::rec_type rec;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   tlvs_req_if req_ch();
   tlvs_rsp_if rsp_ch();
   tlvs_csr_if csr_ch();

   tlv_record_index_scanner DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // scanner state mirror
   logic [31:0]    len_reg;
   logic [31:0]    pos;
   scan_phase_type phase;
   logic [2:0]     hdr_cnt;
   logic [31:0]    id_acc;
   logic [31:0]    size_acc;
   logic [31:0]    skip_cnt;

   tlvs_pkg::rec_type pending_recs[$];
   logic [8:0]        beat_q[$];

   int errors      = 0;
   int bytes_sent  = 0;
   int live_bytes  = 0;
   int recs_seen   = 0;
   int bad_seen    = 0;
   int lens_used   = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int stall_left  = 0;
   int quiet_cycles = 0;

   // length 16: record, one payload byte, short tail, empty record, oversize record
   dir_row_type dir_rows [27] = '{
      '{8'h78, 1'b0, 1'b0, NO_REC},
      '{8'h56, 1'b0, 1'b0, NO_REC},
      '{8'h34, 1'b0, 1'b0, NO_REC},
      '{8'h12, 1'b0, 1'b0, NO_REC},
      '{8'h01, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b1, '{32'h1234_5678, 32'd8, 32'd1, ST_OK}},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'h5A, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b1, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b1, '{32'hFFFF_FFFF, 32'd8, 32'd0, ST_OK}},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'h00, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b0, NO_REC},
      '{8'hFF, 1'b0, 1'b1, '{32'h0000_0000, 32'd16, 32'hFFFF_FFFF, ST_BAD_SIZE}},
      '{8'h33, 1'b0, 1'b0, NO_REC}
   };

   function automatic void restart_scan();
      pos      = '0;
      phase    = PH_HEADER;
      hdr_cnt  = '0;
      id_acc   = '0;
      size_acc = '0;
      skip_cnt = '0;
   endfunction

   function automatic bit scan_byte(input logic [7:0] b, input logic first,
                                    output tlvs_pkg::rec_type r);
      logic [33:0] off_ext;
      bit got;
      got = 1'b0;
      r   = '0;
      if (first) restart_scan();
      case (phase)
         PH_HEADER: begin
            if (hdr_cnt == 3'd0 && {2'b00, pos} + 34'd8 > {2'b00, len_reg}) begin
               phase = PH_STOPPED;
            end else begin
               if (hdr_cnt < 3'd4) id_acc |= 32'(b) << (8 * hdr_cnt);
               else size_acc |= 32'(b) << (8 * (hdr_cnt - 3'd4));
               if (hdr_cnt == 3'd7) begin
                  off_ext          = {2'b00, pos} + 34'd1;
                  hdr_cnt          = '0;
                  r.record_id      = id_acc;
                  r.payload_offset = off_ext[31:0];
                  r.payload_size   = size_acc;
                  if (off_ext + {2'b00, size_acc} > {2'b00, len_reg}) begin
                     r.status = ST_BAD_SIZE;
                     phase    = PH_STOPPED;
                  end else begin
                     r.status = ST_OK;
                     if (size_acc != '0) begin
                        skip_cnt = size_acc;
                        phase    = PH_PAYLOAD;
                     end
                  end
                  id_acc   = '0;
                  size_acc = '0;
                  got      = 1'b1;
               end else begin
                  hdr_cnt = hdr_cnt + 3'd1;
               end
            end
         end
         PH_PAYLOAD: begin
            if (skip_cnt != '0) skip_cnt = skip_cnt - 32'd1;
            if (skip_cnt == '0) phase = PH_HEADER;
         end
         default: ;
      endcase
      // saturate the position
      if (pos != '1) pos = pos + 32'd1;
      return got;
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic first, input bit typed,
                            input tlvs_pkg::rec_type typed_rec);
      tlvs_pkg::rec_type r;
      bit got;
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= b;
      req_ch.buffer_start <= first;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      live_bytes++;
      bytes_sent++;
      got = scan_byte(b, first, r);
      if (typed) pending_recs.push_back(typed_rec);
      else if (got) pending_recs.push_back(r);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_recs.size() != 0) @(posedge clock);
      // a byte that makes no record may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [31:0] value);
      wait_drained();
      csr_ch.valid         <= 1'b1;
      csr_ch.buffer_length <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      len_reg = value;
      lens_used++;
   endtask

   function automatic void add_beat(inout bit lead, input logic [7:0] b);
      beat_q.push_back({lead, b});
      lead = 1'b0;
   endfunction

   task automatic build_buffer(input logic [31:0] blen);
      longint unsigned lim, cap, at, room, sz, n;
      int mode, pick;
      logic [31:0] id_word, size_word;
      bit lead;
      lim  = blen;
      cap  = (lim < 200) ? lim + $urandom_range(3, 0) : $urandom_range(120, 40);
      mode = $urandom_range(9, 0);
      lead = 1'b1;
      if (mode == 0) begin
         // noise with stray start marks
         n = $urandom_range(30, 1);
         repeat (n) beat_q.push_back({($urandom_range(7, 0) == 0), 8'($urandom)});
      end else if (mode == 1) begin
         // header cut short by the next buffer's start
         add_beat(lead, 8'($urandom));
         repeat ($urandom_range(6, 0)) add_beat(lead, 8'($urandom));
      end else begin
         at = 0;
         while (at < cap) begin
            if (at + 8 > lim) begin
               while (at < cap) begin
                  add_beat(lead, 8'($urandom));
                  at++;
               end
            end else begin
               id_word = $urandom;
               room    = lim - at - 8;
               pick    = $urandom_range(9, 0);
               if (pick < 6) sz = $urandom_range(int'((room < 12) ? room : 12), 0);
               else if (pick < 8) sz = 0;
               else if (pick == 8) sz = room + $urandom_range(4, 1);
               else sz = $urandom;
               size_word = 32'(sz);
               for (int k = 0; k < 4; k++) add_beat(lead, id_word[8*k +: 8]);
               for (int k = 0; k < 4; k++) add_beat(lead, size_word[8*k +: 8]);
               at += 8;
               if (at + size_word > lim) begin
                  // oversize: rest of the buffer is dropped
                  repeat ($urandom_range(4, 0)) add_beat(lead, 8'($urandom));
                  at = cap;
               end else begin
                  n = (at >= cap) ? 0 : ((size_word < cap - at) ? size_word : cap - at);
                  repeat (n) add_beat(lead, 8'($urandom));
                  at += size_word;
               end
            end
         end
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      tlvs_pkg::rec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_recs.size() == 0) begin
            errors++;
            $display({"%0t: record with none expected, expected nothing, ",
                      "actual id=%h off=%h size=%h status=%b"},
                     $time, rsp_ch.record_id, rsp_ch.payload_offset, rsp_ch.payload_size,
                     rsp_ch.status);
         end else begin
            want = pending_recs.pop_front();
            recs_seen++;
            if (want.status == ST_BAD_SIZE) bad_seen++;
            check_field("record_id", want.record_id, rsp_ch.record_id);
            check_field("payload_offset", want.payload_offset, rsp_ch.payload_offset);
            check_field("payload_size", want.payload_size, rsp_ch.payload_size);
            check_field("status", 32'(want.status), 32'(rsp_ch.status));
         end
      end
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else if ($urandom_range(99, 0) < stall_pct) begin
         stall_left   <= $urandom_range(19, 1);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] len_pick;
      int lens_idx, buf_count, phase_base;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.data_byte     <= '0;
      req_ch.buffer_start  <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.buffer_length <= '0;
      len_reg = '0;
      restart_scan();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      write_length(32'd16);
      foreach (dir_rows[i])
         send_beat(dir_rows[i].data, dir_rows[i].first, dir_rows[i].typed, dir_rows[i].rec);

      live_bytes = 0;
      lens_idx   = 0;
      while (live_bytes < RANDOM_BYTES) begin
         case (lens_idx)
            0: len_pick = 32'd0;
            1: len_pick = 32'd8;
            2: len_pick = 32'hFFFF_FFFF;
            3: len_pick = 32'd9;
            4: len_pick = 32'd7;
            default: begin
               if ($urandom_range(9, 0) < 7) len_pick = $urandom_range(90, 10);
               else if ($urandom_range(1, 0) == 0) len_pick = $urandom_range(300, 91);
               else len_pick = $urandom;
            end
         endcase
         if (RANDOM_BYTES - live_bytes <= QUIET_TAIL || $urandom_range(3, 0) == 0) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = $urandom_range(20, 3);
            stall_pct = $urandom_range(20, 3);
         end
         write_length(len_pick);
         buf_count  = 0;
         phase_base = live_bytes;
         while (live_bytes - phase_base < PHASE_BYTES && buf_count < PHASE_BUFFERS &&
                live_bytes < RANDOM_BYTES) begin
            if (RANDOM_BYTES - live_bytes <= QUIET_TAIL) begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            build_buffer(len_pick);
            while (beat_q.size() != 0) begin
               logic [8:0] beat;
               beat = beat_q.pop_front();
               send_beat(beat[7:0], beat[8], 1'b0, NO_REC);
            end
            buf_count++;
            // hold the sender until every record is out
            if (lens_idx == 2) wait_drained();
         end
         lens_idx++;
      end

      wait_drained();
      $display("Sent %0d bytes under %0d buffer lengths (zero, seven to nine, all ones, random).",
               bytes_sent, lens_used);
      $display("Compared %0d records, %0d of them with bad size status.", recs_seen, bad_seen);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/tlvs_pkg.sv
rtl/tlvs_ifs.sv
rtl/tlvs_front.sv
rtl/tlvs_queue.sv
rtl/tlv_record_index_scanner.sv
tb/sv/tlv_record_index_scanner_tb.sv
